>>> hdl/rci_pkg.sv
package rci_pkg;

    // default number of fraction bits
    localparam int FRAC_BITS_DEF = 16;

    // width of a magnitude of -h - sqrt(disc)
    localparam int MAG_W = 33;

    // result bits of the square root
    localparam int ROOT_W = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 3'd7;

    // register reset values
    localparam logic signed [31:0] AXIS_Y_RST = 32'sd65536;
    localparam logic [30:0]        RADIUS_RST = 31'd65536;
    localparam logic [30:0]        MAXD_RST   = 31'd9830400;

    localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

    typedef logic signed [31:0] val_t;

    // ray data that rides along the arithmetic
    typedef struct packed {
        logic miss;
        val_t ox;
        val_t oy;
        val_t oz;
        val_t vx;
        val_t vy;
        val_t vz;
    } ray_side_t;

    // ray data plus the quadratic terms needed after the root
    typedef struct packed {
        ray_side_t ray;
        val_t      h;
        logic [30:0] a;
    } quad_side_t;

    // one result
    typedef struct packed {
        logic hit;
        val_t t;
        val_t x;
        val_t y;
        val_t z;
    } res_t;

    // clamp to the signed 32 bit range
    function automatic val_t sat32(input logic signed [65:0] v);
        val_t r;
        if (v > 66'sd2147483647)
            r = VAL_MAX;
        else if (v < -66'sd2147483648)
            r = VAL_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> hdl/rci_front.sv
module rci_front #(
    parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  rci_pkg::val_t        origin_x,
    input  rci_pkg::val_t        origin_y,
    input  rci_pkg::val_t        origin_z,
    input  rci_pkg::val_t        dir_x,
    input  rci_pkg::val_t        dir_y,
    input  rci_pkg::val_t        dir_z,
    input  rci_pkg::val_t        center_x,
    input  rci_pkg::val_t        center_y,
    input  rci_pkg::val_t        center_z,
    input  rci_pkg::val_t        axis_x,
    input  rci_pkg::val_t        axis_y,
    input  rci_pkg::val_t        axis_z,
    input  logic [30:0]          cyl_radius,
    output logic                 q_valid,
    output logic [63:0]          disc,
    output rci_pkg::quad_side_t  q_side
);

    function automatic logic signed [63:0] fl(input logic signed [63:0] p);
        return p >>> FRAC_BITS;
    endfunction

    rci_pkg::val_t in_o [3];
    rci_pkg::val_t in_v [3];
    rci_pkg::val_t ctr [3];
    rci_pkg::val_t ax [3];

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg;

    rci_pkg::val_t s1_o_reg [3], s1_v_reg [3], s1_w_reg [3];
    logic signed [63:0] s2_pv_reg [6], s2_pw_reg [6], s2_aa_reg [3];
    logic [61:0] s2_rr_reg;
    rci_pkg::val_t s2_o_reg [3], s2_v_reg [3];
    rci_pkg::val_t s3_vd_reg [3], s3_wd_reg [3];
    logic [30:0] s3_r2_reg, s3_d2_reg;
    rci_pkg::val_t s3_o_reg [3], s3_v_reg [3];
    logic signed [63:0] s4_vv_reg [3], s4_vw_reg [3], s4_ww_reg [3];
    logic [61:0] s4_rd_reg;
    rci_pkg::val_t s4_o_reg [3], s4_v_reg [3];
    rci_pkg::val_t s5_a_reg, s5_h_reg, s5_c_reg;
    rci_pkg::val_t s5_o_reg [3], s5_v_reg [3];
    logic signed [63:0] s6_hh_reg, s6_ac_reg;
    rci_pkg::val_t s6_h_reg;
    logic [30:0] s6_a_reg;
    logic s6_miss_reg;
    rci_pkg::val_t s6_o_reg [3], s6_v_reg [3];
    logic [63:0] s7_disc_reg;
    rci_pkg::val_t s7_h_reg;
    logic [30:0] s7_a_reg;
    logic s7_miss_reg;
    rci_pkg::val_t s7_o_reg [3], s7_v_reg [3];

    rci_pkg::val_t w_next [3];
    rci_pkg::val_t vd_next [3], wd_next [3];
    rci_pkg::val_t r2_sat, d2_sat;
    rci_pkg::val_t a_next, h_next, c_next;
    logic s6_miss_next;
    logic [30:0] s6_a_next;
    logic signed [64:0] disc_full;
    logic s7_miss_next;

    assign in_o[0] = origin_x;
    assign in_o[1] = origin_y;
    assign in_o[2] = origin_z;
    assign in_v[0] = dir_x;
    assign in_v[1] = dir_y;
    assign in_v[2] = dir_z;
    assign ctr[0]  = center_x;
    assign ctr[1]  = center_y;
    assign ctr[2]  = center_z;
    assign ax[0]   = axis_x;
    assign ax[1]   = axis_y;
    assign ax[2]   = axis_z;

    // stage logic between registers
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            w_next[i] = rci_pkg::sat32(66'(in_o[i]) - 66'(ctr[i]));
        end
        for (int k = 0; k < 3; k++)
        begin
            vd_next[k] = rci_pkg::sat32(66'(fl(s2_pv_reg[2*k])) - 66'(fl(s2_pv_reg[2*k+1])));
            wd_next[k] = rci_pkg::sat32(66'(fl(s2_pw_reg[2*k])) - 66'(fl(s2_pw_reg[2*k+1])));
        end
        r2_sat = rci_pkg::sat32($signed(66'(s2_rr_reg >> FRAC_BITS)));
        d2_sat = rci_pkg::sat32(66'(fl(s2_aa_reg[0])) + 66'(fl(s2_aa_reg[1]))
                                + 66'(fl(s2_aa_reg[2])));
        a_next = rci_pkg::sat32(66'(fl(s4_vv_reg[0])) + 66'(fl(s4_vv_reg[1]))
                                + 66'(fl(s4_vv_reg[2])));
        h_next = rci_pkg::sat32(66'(fl(s4_vw_reg[0])) + 66'(fl(s4_vw_reg[1]))
                                + 66'(fl(s4_vw_reg[2])));
        c_next = rci_pkg::sat32(66'(fl(s4_ww_reg[0])) + 66'(fl(s4_ww_reg[1]))
                                + 66'(fl(s4_ww_reg[2]))
                                - $signed(66'(s4_rd_reg >> FRAC_BITS)));
        s6_miss_next = (s5_a_reg <= 32'sd0);
        s6_a_next    = s6_miss_next ? 31'd1 : s5_a_reg[30:0];
        disc_full    = 65'(s6_hh_reg) - 65'(s6_ac_reg);
        s7_miss_next = s6_miss_reg || disc_full[64];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // offset from the base point
            for (int i = 0; i < 3; i++)
            begin
                s1_o_reg[i] <= in_o[i];
                s1_v_reg[i] <= in_v[i];
                s1_w_reg[i] <= w_next[i];
            end

            // cross product terms and config squares
            s2_pv_reg[0] <= 64'(s1_v_reg[1]) * 64'(ax[2]);
            s2_pv_reg[1] <= 64'(s1_v_reg[2]) * 64'(ax[1]);
            s2_pv_reg[2] <= 64'(s1_v_reg[2]) * 64'(ax[0]);
            s2_pv_reg[3] <= 64'(s1_v_reg[0]) * 64'(ax[2]);
            s2_pv_reg[4] <= 64'(s1_v_reg[0]) * 64'(ax[1]);
            s2_pv_reg[5] <= 64'(s1_v_reg[1]) * 64'(ax[0]);
            s2_pw_reg[0] <= 64'(s1_w_reg[1]) * 64'(ax[2]);
            s2_pw_reg[1] <= 64'(s1_w_reg[2]) * 64'(ax[1]);
            s2_pw_reg[2] <= 64'(s1_w_reg[2]) * 64'(ax[0]);
            s2_pw_reg[3] <= 64'(s1_w_reg[0]) * 64'(ax[2]);
            s2_pw_reg[4] <= 64'(s1_w_reg[0]) * 64'(ax[1]);
            s2_pw_reg[5] <= 64'(s1_w_reg[1]) * 64'(ax[0]);
            for (int i = 0; i < 3; i++)
            begin
                s2_aa_reg[i] <= 64'(ax[i]) * 64'(ax[i]);
            end
            s2_rr_reg <= 62'(cyl_radius) * 62'(cyl_radius);

            // cross products
            for (int i = 0; i < 3; i++)
            begin
                s3_vd_reg[i] <= vd_next[i];
                s3_wd_reg[i] <= wd_next[i];
            end
            s3_r2_reg <= r2_sat[30:0];
            s3_d2_reg <= d2_sat[30:0];

            // dot product terms
            for (int i = 0; i < 3; i++)
            begin
                s4_vv_reg[i] <= 64'(s3_vd_reg[i]) * 64'(s3_vd_reg[i]);
                s4_vw_reg[i] <= 64'(s3_vd_reg[i]) * 64'(s3_wd_reg[i]);
                s4_ww_reg[i] <= 64'(s3_wd_reg[i]) * 64'(s3_wd_reg[i]);
            end
            s4_rd_reg <= 62'(s3_r2_reg) * 62'(s3_d2_reg);

            // quadratic coefficients
            s5_a_reg <= a_next;
            s5_h_reg <= h_next;
            s5_c_reg <= c_next;

            // discriminant terms
            s6_hh_reg   <= 64'(s5_h_reg) * 64'(s5_h_reg);
            s6_ac_reg   <= 64'(s5_a_reg) * 64'(s5_c_reg);
            s6_h_reg    <= s5_h_reg;
            s6_a_reg    <= s6_a_next;
            s6_miss_reg <= s6_miss_next;

            // discriminant
            s7_disc_reg <= s7_miss_next ? 64'd0 : disc_full[63:0];
            s7_h_reg    <= s6_h_reg;
            s7_a_reg    <= s6_a_reg;
            s7_miss_reg <= s7_miss_next;

            // ray carried along
            for (int i = 0; i < 3; i++)
            begin
                s2_o_reg[i] <= s1_o_reg[i];
                s2_v_reg[i] <= s1_v_reg[i];
                s3_o_reg[i] <= s2_o_reg[i];
                s3_v_reg[i] <= s2_v_reg[i];
                s4_o_reg[i] <= s3_o_reg[i];
                s4_v_reg[i] <= s3_v_reg[i];
                s5_o_reg[i] <= s4_o_reg[i];
                s5_v_reg[i] <= s4_v_reg[i];
                s6_o_reg[i] <= s5_o_reg[i];
                s6_v_reg[i] <= s5_v_reg[i];
                s7_o_reg[i] <= s6_o_reg[i];
                s7_v_reg[i] <= s6_v_reg[i];
            end
        end
    end

    assign q_valid        = s7_valid_reg;
    assign disc           = s7_disc_reg;
    assign q_side.ray.miss = s7_miss_reg;
    assign q_side.ray.ox  = s7_o_reg[0];
    assign q_side.ray.oy  = s7_o_reg[1];
    assign q_side.ray.oz  = s7_o_reg[2];
    assign q_side.ray.vx  = s7_v_reg[0];
    assign q_side.ray.vy  = s7_v_reg[1];
    assign q_side.ray.vz  = s7_v_reg[2];
    assign q_side.h       = s7_h_reg;
    assign q_side.a       = s7_a_reg;

endmodule

>>> hdl/rci_sqrt.sv
module rci_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       d_valid,
    input  logic [63:0]                disc,
    input  rci_pkg::quad_side_t        d_side,
    output logic                       r_valid,
    output logic [rci_pkg::ROOT_W-1:0] root,
    output rci_pkg::quad_side_t        r_side
);

    localparam int STEPS = rci_pkg::ROOT_W;
    localparam int REM_W = rci_pkg::ROOT_W + 2;

    logic                valid_reg [STEPS];
    logic [REM_W-1:0]    rem_reg   [STEPS];
    logic [STEPS-1:0]    root_reg  [STEPS];
    logic [2*STEPS-1:0]  x_reg     [STEPS];
    rci_pkg::quad_side_t side_reg  [STEPS];

    // one result bit per stage, two radicand bits consumed each time
    for (genvar g = 0; g < STEPS; g++)
    begin : g_step
        logic                v_in;
        logic [REM_W-1:0]    rem_in;
        logic [STEPS-1:0]    root_in;
        logic [2*STEPS-1:0]  x_in;
        rci_pkg::quad_side_t side_in;
        logic [REM_W+1:0]    cur;
        logic [REM_W+1:0]    trial;
        logic                take;
        logic [REM_W+1:0]    diff;

        if (g == 0)
        begin : g_first
            assign v_in    = d_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = disc;
            assign side_in = d_side;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign x_in    = x_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        assign cur   = {rem_in, x_in[2*STEPS-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign take  = (cur >= trial);
        assign diff  = cur - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else if (en)
                valid_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= take ? diff[REM_W-1:0] : cur[REM_W-1:0];
                root_reg[g] <= {root_in[STEPS-2:0], take};
                x_reg[g]    <= {x_in[2*STEPS-3:0], 2'b00};
                side_reg[g] <= side_in;
            end
        end
    end

    assign r_valid = valid_reg[STEPS-1];
    assign root    = root_reg[STEPS-1];
    assign r_side  = side_reg[STEPS-1];

endmodule

>>> hdl/rci_div.sv
module rci_div #(
    parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       r_valid,
    input  logic [rci_pkg::ROOT_W-1:0] root,
    input  rci_pkg::quad_side_t        r_side,
    output logic                       t_valid,
    output rci_pkg::val_t              t_val,
    output rci_pkg::ray_side_t         t_side
);

    localparam int DW = rci_pkg::MAG_W + FRAC_BITS;

    // numerator -h - s and its magnitude
    logic signed [rci_pkg::MAG_W:0]   num;
    logic signed [rci_pkg::MAG_W:0]   num_neg;
    logic [rci_pkg::MAG_W-1:0]        mag;

    logic               p_valid_reg;
    logic [DW-1:0]      p_dvd_reg;
    logic               p_neg_reg;
    logic [30:0]        p_a_reg;
    rci_pkg::ray_side_t p_side_reg;

    logic               valid_reg [DW];
    logic [30:0]        rem_reg   [DW];
    logic [DW-1:0]      dvd_reg   [DW];
    logic               neg_reg   [DW];
    logic [30:0]        a_reg     [DW];
    rci_pkg::ray_side_t side_reg  [DW];

    logic               t_valid_reg;
    rci_pkg::val_t      t_reg;
    rci_pkg::ray_side_t t_side_reg;

    logic [DW-1:0]      quo;
    logic [DW-1:0]      quo_neg;
    rci_pkg::val_t      t_next;

    assign num     = -(rci_pkg::MAG_W+1)'(r_side.h) - $signed({2'b00, root});
    assign num_neg = -num;
    assign mag     = num[rci_pkg::MAG_W] ? num_neg[rci_pkg::MAG_W-1:0]
                                         : num[rci_pkg::MAG_W-1:0];

    // prepare the scaled dividend
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= r_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_dvd_reg  <= {mag, {FRAC_BITS{1'b0}}};
            p_neg_reg  <= num[rci_pkg::MAG_W];
            p_a_reg    <= r_side.a;
            p_side_reg <= r_side.ray;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar g = 0; g < DW; g++)
    begin : g_step
        logic               v_in;
        logic [30:0]        rem_in;
        logic [DW-1:0]      dvd_in;
        logic               neg_in;
        logic [30:0]        a_in;
        rci_pkg::ray_side_t side_in;
        logic [31:0]        cur;
        logic [31:0]        diff;
        logic               take;

        if (g == 0)
        begin : g_first
            assign v_in    = p_valid_reg;
            assign rem_in  = '0;
            assign dvd_in  = p_dvd_reg;
            assign neg_in  = p_neg_reg;
            assign a_in    = p_a_reg;
            assign side_in = p_side_reg;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign dvd_in  = dvd_reg[g-1];
            assign neg_in  = neg_reg[g-1];
            assign a_in    = a_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        assign cur  = {rem_in, dvd_in[DW-1]};
        assign take = (cur >= {1'b0, a_in});
        assign diff = cur - {1'b0, a_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else if (en)
                valid_reg[g] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= take ? diff[30:0] : cur[30:0];
                dvd_reg[g]  <= {dvd_in[DW-2:0], take};
                neg_reg[g]  <= neg_in;
                a_reg[g]    <= a_in;
                side_reg[g] <= side_in;
            end
        end
    end

    // sign and clamp of the quotient
    assign quo     = dvd_reg[DW-1];
    assign quo_neg = -quo;

    always_comb
    begin
        if (!neg_reg[DW-1])
        begin
            if (quo > DW'(32'h7fffffff))
                t_next = rci_pkg::VAL_MAX;
            else
                t_next = quo[31:0];
        end
        else
        begin
            if (quo > DW'(32'h80000000))
                t_next = rci_pkg::VAL_MIN;
            else
                t_next = quo_neg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_valid_reg <= 1'b0;
        else if (en)
            t_valid_reg <= valid_reg[DW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg      <= t_next;
            t_side_reg <= side_reg[DW-1];
        end
    end

    assign t_valid = t_valid_reg;
    assign t_val   = t_reg;
    assign t_side  = t_side_reg;

endmodule

>>> hdl/rci_back.sv
module rci_back #(
    parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               t_valid,
    input  rci_pkg::val_t      t_val,
    input  rci_pkg::ray_side_t t_side,
    input  logic [30:0]        max_distance,
    output logic               res_valid,
    output rci_pkg::res_t      res
);

    rci_pkg::val_t in_o [3];
    rci_pkg::val_t in_v [3];

    logic b1_valid_reg, b2_valid_reg, b3_valid_reg, b4_valid_reg;

    logic signed [63:0] b1_p_reg [3];
    rci_pkg::val_t      b1_o_reg [3];
    rci_pkg::val_t      b1_t_reg;
    logic               b1_miss_reg;

    logic [30:0]        b2_mc_reg [3];
    rci_pkg::val_t      b2_pt_reg [3];
    rci_pkg::val_t      b2_t_reg;
    logic               b2_far_reg;
    logic               b2_miss_reg;

    logic [61:0]        b3_sq_reg [3];
    logic [61:0]        b3_lim2_reg;
    rci_pkg::val_t      b3_pt_reg [3];
    rci_pkg::val_t      b3_t_reg;
    logic               b3_far_reg;
    logic               b3_miss_reg;

    rci_pkg::res_t      b4_res_reg;

    logic signed [63:0] d_step [3];
    logic signed [63:0] d_neg [3];
    logic [63:0]        m_abs [3];
    logic [30:0]        mc_next [3];
    rci_pkg::val_t      pt_next [3];
    logic               far_next;
    logic [63:0]        dist2;
    logic               hit_next;
    rci_pkg::res_t      res_next;

    assign in_o[0] = t_side.ox;
    assign in_o[1] = t_side.oy;
    assign in_o[2] = t_side.oz;
    assign in_v[0] = t_side.vx;
    assign in_v[1] = t_side.vy;
    assign in_v[2] = t_side.vz;

    // step lengths, distance checks and hit point
    always_comb
    begin
        far_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            d_step[i]  = b1_p_reg[i] >>> FRAC_BITS;
            d_neg[i]   = -d_step[i];
            m_abs[i]   = d_step[i][63] ? d_neg[i] : d_step[i];
            mc_next[i] = m_abs[i][30:0];
            pt_next[i] = rci_pkg::sat32(66'(b1_o_reg[i]) + 66'(d_step[i]));
            if (m_abs[i] > {33'd0, max_distance})
                far_next = 1'b1;
        end
        dist2    = 64'(b3_sq_reg[0]) + 64'(b3_sq_reg[1]) + 64'(b3_sq_reg[2]);
        hit_next = !b3_miss_reg && !b3_far_reg && (dist2 <= 64'(b3_lim2_reg));
        res_next.hit = hit_next;
        res_next.t   = hit_next ? b3_t_reg     : '0;
        res_next.x   = hit_next ? b3_pt_reg[0] : '0;
        res_next.y   = hit_next ? b3_pt_reg[1] : '0;
        res_next.z   = hit_next ? b3_pt_reg[2] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= t_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // direction times parameter
            for (int i = 0; i < 3; i++)
            begin
                b1_p_reg[i] <= 64'(in_v[i]) * 64'(t_val);
                b1_o_reg[i] <= in_o[i];
            end
            b1_t_reg    <= t_val;
            b1_miss_reg <= t_side.miss;

            // per axis limits and hit point
            for (int i = 0; i < 3; i++)
            begin
                b2_mc_reg[i] <= mc_next[i];
                b2_pt_reg[i] <= pt_next[i];
            end
            b2_t_reg    <= b1_t_reg;
            b2_far_reg  <= far_next;
            b2_miss_reg <= b1_miss_reg;

            // squared lengths
            for (int i = 0; i < 3; i++)
            begin
                b3_sq_reg[i] <= 62'(b2_mc_reg[i]) * 62'(b2_mc_reg[i]);
                b3_pt_reg[i] <= b2_pt_reg[i];
            end
            b3_lim2_reg <= 62'(max_distance) * 62'(max_distance);
            b3_t_reg    <= b2_t_reg;
            b3_far_reg  <= b2_far_reg;
            b3_miss_reg <= b2_miss_reg;

            // final result
            b4_res_reg <= res_next;
        end
    end

    assign res_valid = b4_valid_reg;
    assign res       = b4_res_reg;

endmodule

>>> hdl/ray_cylinder_intersect.sv
// throughput: one ray per cycle while in_stall is low;
// set by a fully pipelined datapath of one stage per step
// square root takes 32 stages, the divider 33 + FRAC_BITS stages, one bit each
// a two entry output buffer keeps the input open while one result waits
// reset: asynchronous active low; clears valid bits and buffer count, loads config reset values
module ray_cylinder_intersect #(
    parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  rci_pkg::val_t                 origin_x,
    input  rci_pkg::val_t                 origin_y,
    input  rci_pkg::val_t                 origin_z,
    input  rci_pkg::val_t                 dir_x,
    input  rci_pkg::val_t                 dir_y,
    input  rci_pkg::val_t                 dir_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output rci_pkg::val_t                 ray_param,
    output rci_pkg::val_t                 hit_x,
    output rci_pkg::val_t                 hit_y,
    output rci_pkg::val_t                 hit_z,
    input  logic                          cfg_we,
    input  logic [rci_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    rci_pkg::val_t center_x_reg, center_y_reg, center_z_reg;
    rci_pkg::val_t axis_x_reg, axis_y_reg, axis_z_reg;
    logic [30:0]   radius_reg, max_dist_reg;

    logic                       en;
    logic                       q_valid;
    logic [63:0]                disc;
    rci_pkg::quad_side_t        q_side;
    logic                       r_valid;
    logic [rci_pkg::ROOT_W-1:0] root;
    rci_pkg::quad_side_t        r_side;
    logic                       t_valid;
    rci_pkg::val_t              t_val;
    rci_pkg::ray_side_t         t_side;
    logic                       b_valid;
    rci_pkg::res_t              b_res;

    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;
    rci_pkg::res_t slot0_reg, slot1_reg;
    logic          push, pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            axis_x_reg   <= '0;
            axis_y_reg   <= rci_pkg::AXIS_Y_RST;
            axis_z_reg   <= '0;
            radius_reg   <= rci_pkg::RADIUS_RST;
            max_dist_reg <= rci_pkg::MAXD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rci_pkg::CFG_CENTER_X: center_x_reg <= cfg_data;
                rci_pkg::CFG_CENTER_Y: center_y_reg <= cfg_data;
                rci_pkg::CFG_CENTER_Z: center_z_reg <= cfg_data;
                rci_pkg::CFG_AXIS_X:   axis_x_reg   <= cfg_data;
                rci_pkg::CFG_AXIS_Y:   axis_y_reg   <= cfg_data;
                rci_pkg::CFG_AXIS_Z:   axis_z_reg   <= cfg_data;
                rci_pkg::CFG_RADIUS:   radius_reg   <= cfg_data[30:0];
                rci_pkg::CFG_MAX_DIST: max_dist_reg <= cfg_data[30:0];
            endcase
        end
    end

    // pipeline moves whenever the output buffer has room
    assign en       = (cnt_reg != 2'd2);
    assign in_stall = !en;

    rci_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .origin_z   (origin_z),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .center_x   (center_x_reg),
        .center_y   (center_y_reg),
        .center_z   (center_z_reg),
        .axis_x     (axis_x_reg),
        .axis_y     (axis_y_reg),
        .axis_z     (axis_z_reg),
        .cyl_radius (radius_reg),
        .q_valid    (q_valid),
        .disc       (disc),
        .q_side     (q_side)
    );

    rci_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .d_valid (q_valid),
        .disc    (disc),
        .d_side  (q_side),
        .r_valid (r_valid),
        .root    (root),
        .r_side  (r_side)
    );

    rci_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .r_valid (r_valid),
        .root    (root),
        .r_side  (r_side),
        .t_valid (t_valid),
        .t_val   (t_val),
        .t_side  (t_side)
    );

    rci_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .t_valid      (t_valid),
        .t_val        (t_val),
        .t_side       (t_side),
        .max_distance (max_dist_reg),
        .res_valid    (b_valid),
        .res          (b_res)
    );

    // two entry output buffer
    assign push     = en && b_valid;
    assign pop      = (cnt_reg != 2'd0) && !out_stall;
    assign cnt_next = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (push && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop)))
            slot0_reg <= b_res;
        else if (pop && (cnt_reg == 2'd2))
            slot0_reg <= slot1_reg;

        if (push && (cnt_reg == 2'd1) && !pop)
            slot1_reg <= b_res;
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign hit       = slot0_reg.hit;
    assign ray_param = slot0_reg.t;
    assign hit_x     = slot0_reg.x;
    assign hit_y     = slot0_reg.y;
    assign hit_z     = slot0_reg.z;

endmodule

>>> bench/rci_checker.sv
module rci_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  rci_pkg::val_t                 origin_x,
    input  rci_pkg::val_t                 origin_y,
    input  rci_pkg::val_t                 origin_z,
    input  rci_pkg::val_t                 dir_x,
    input  rci_pkg::val_t                 dir_y,
    input  rci_pkg::val_t                 dir_z,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          hit,
    input  rci_pkg::val_t                 ray_param,
    input  rci_pkg::val_t                 hit_x,
    input  rci_pkg::val_t                 hit_y,
    input  rci_pkg::val_t                 hit_z,
    input  logic                          cfg_we,
    input  logic [rci_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output int                            fail_count,
    output int                            pending,
    output int                            hit_count,
    output int                            result_count
);

    localparam int FB = rci_pkg::FRAC_BITS_DEF;

    // shadow copy of the cylinder registers
    longint cen_x, cen_y, cen_z;
    longint ax_x, ax_y, ax_z;
    longint radius, max_dist;

    rci_pkg::res_t expected_hits[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // floor of v / 2^FB
    function automatic longint fl(input longint v);
        return v >>> FB;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    task automatic cross3(input longint a0, a1, a2, b0, b1, b2,
                          output longint c0, c1, c2);
        c0 = clamp32(fl(a1 * b2) - fl(a2 * b1));
        c1 = clamp32(fl(a2 * b0) - fl(a0 * b2));
        c2 = clamp32(fl(a0 * b1) - fl(a1 * b0));
    endtask

    // intersection of one ray with the configured cylinder
    task automatic predict_hit(input longint o0, o1, o2, v0, v1, v2,
                               output rci_pkg::res_t r);
        longint w0, w1, w2, vd0, vd1, vd2, wd0, wd1, wd2;
        longint a, h, c, r2, d2, ac, num, t, d;
        longint unsigned hh, disc, dist2, lim, m;
        longint o[3], v[3], dd[3];
        r = '0;
        o[0] = o0; o[1] = o1; o[2] = o2;
        v[0] = v0; v[1] = v1; v[2] = v2;
        w0 = clamp32(o0 - cen_x);
        w1 = clamp32(o1 - cen_y);
        w2 = clamp32(o2 - cen_z);
        cross3(v0, v1, v2, ax_x, ax_y, ax_z, vd0, vd1, vd2);
        cross3(w0, w1, w2, ax_x, ax_y, ax_z, wd0, wd1, wd2);
        a = clamp32(fl(vd0 * vd0) + fl(vd1 * vd1) + fl(vd2 * vd2));
        h = clamp32(fl(vd0 * wd0) + fl(vd1 * wd1) + fl(vd2 * wd2));
        r2 = clamp32(fl(radius * radius));
        d2 = clamp32(fl(ax_x * ax_x) + fl(ax_y * ax_y) + fl(ax_z * ax_z));
        c = clamp32(fl(wd0 * wd0) + fl(wd1 * wd1) + fl(wd2 * wd2) - fl(r2 * d2));
        // degenerate quadratic
        if (a <= 0)
            return;
        hh = h * h;
        ac = a * c;
        if (ac <= 0)
            disc = hh + longint'(-ac);
        else
        begin
            // no real root
            if (longint'(ac) > 0 && ac > hh)
                return;
            disc = hh - ac;
        end
        num = -h - longint'(int_sqrt(disc));
        t = clamp32((num * (64'sd1 << FB)) / a);
        // distance limit on each step and on the squared length
        dist2 = 0;
        lim = max_dist;
        for (int i = 0; i < 3; i++)
        begin
            d = fl(v[i] * t);
            m = (d < 0) ? -d : d;
            if (m > lim)
                return;
            dist2 = dist2 + m * m;
            dd[i] = d;
        end
        if (dist2 > lim * lim)
            return;
        r.hit = 1'b1;
        r.t = rci_pkg::val_t'(t);
        r.x = rci_pkg::val_t'(clamp32(o[0] + dd[0]));
        r.y = rci_pkg::val_t'(clamp32(o[1] + dd[1]));
        r.z = rci_pkg::val_t'(clamp32(o[2] + dd[2]));
    endtask

    // register writes, accepted requests and accepted results
    always @(posedge clk or negedge rst_n)
    begin
        rci_pkg::res_t exp_r;
        rci_pkg::res_t got;
        if (!rst_n)
        begin
            cen_x = 0; cen_y = 0; cen_z = 0;
            ax_x = 0; ax_y = longint'(rci_pkg::AXIS_Y_RST); ax_z = 0;
            radius = longint'(rci_pkg::RADIUS_RST);
            max_dist = longint'(rci_pkg::MAXD_RST);
            expected_hits.delete();
            fail_count = 0;
            hit_count = 0;
            result_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rci_pkg::CFG_CENTER_X: cen_x = longint'(signed'(cfg_data));
                    rci_pkg::CFG_CENTER_Y: cen_y = longint'(signed'(cfg_data));
                    rci_pkg::CFG_CENTER_Z: cen_z = longint'(signed'(cfg_data));
                    rci_pkg::CFG_AXIS_X:   ax_x = longint'(signed'(cfg_data));
                    rci_pkg::CFG_AXIS_Y:   ax_y = longint'(signed'(cfg_data));
                    rci_pkg::CFG_AXIS_Z:   ax_z = longint'(signed'(cfg_data));
                    rci_pkg::CFG_RADIUS:   radius = longint'({33'd0, cfg_data[30:0]});
                    rci_pkg::CFG_MAX_DIST: max_dist = longint'({33'd0, cfg_data[30:0]});
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                predict_hit(origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, exp_r);
                expected_hits.push_back(exp_r);
            end
            if (out_valid && !out_stall)
            begin
                got = '{hit, ray_param, hit_x, hit_y, hit_z};
                result_count++;
                if (hit)
                    hit_count++;
                if (expected_hits.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result hit=%0b t=%0d", hit, ray_param);
                end
                else
                begin
                    exp_r = expected_hits.pop_front();
                    if (got !== exp_r)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch result %0d: hit %0b/%0b t %0d/%0d",
                                      " x %0d/%0d y %0d/%0d z %0d/%0d (exp/got)"},
                                     result_count, exp_r.hit, got.hit, exp_r.t, got.t,
                                     exp_r.x, got.x, exp_r.y, got.y, exp_r.z, got.z);
                    end
                end
            end
        end
        pending = expected_hits.size();
    end

endmodule

>>> bench/tb_ray_cylinder_intersect.sv
module tb_ray_cylinder_intersect;

    localparam int ONE = 65536;
    localparam int IDLE_LIMIT = 6000;
    localparam int HOLD_CYCLES = 400;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    rci_pkg::val_t                 origin_x, origin_y, origin_z;
    rci_pkg::val_t                 dir_x, dir_y, dir_z;
    logic                          out_valid;
    logic                          out_stall;
    logic                          hit;
    rci_pkg::val_t                 ray_param, hit_x, hit_y, hit_z;
    logic                          cfg_we;
    logic [rci_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                   cfg_data;

    int  fail_count, pending, hit_count, result_count;
    int  rays_sent;
    int  idle_cycles;
    bit  calm;
    bit  hold_now;
    rci_pkg::val_t cur_cx, cur_cy, cur_cz;

    ray_cylinder_intersect u_dut (.*);

    rci_checker u_check (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("ray_cylinder_intersect verification failed");
            $finish;
        end
    end

    // result side: random stalls, quiet stretch, one long hold-off
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_now)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_now = 1'b0;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 9);
        end
    end

    task automatic write_reg(input logic [rci_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic set_cylinder(input rci_pkg::val_t cx, cy, cz, axx, axy, axz,
                                input logic [31:0] rad, maxd);
        write_reg(rci_pkg::CFG_CENTER_X, cx);
        write_reg(rci_pkg::CFG_CENTER_Y, cy);
        write_reg(rci_pkg::CFG_CENTER_Z, cz);
        write_reg(rci_pkg::CFG_AXIS_X, axx);
        write_reg(rci_pkg::CFG_AXIS_Y, axy);
        write_reg(rci_pkg::CFG_AXIS_Z, axz);
        write_reg(rci_pkg::CFG_RADIUS, rad);
        write_reg(rci_pkg::CFG_MAX_DIST, maxd);
        cfg_we <= 1'b0;
        cur_cx = cx;
        cur_cy = cy;
        cur_cz = cz;
        @(posedge clk);
    endtask

    // wait for every outstanding result, then for the pipeline to empty
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic send_ray(input rci_pkg::val_t ox, oy, oz, vx, vy, vz);
        if (!calm && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        origin_x <= ox;
        origin_y <= oy;
        origin_z <= oz;
        dir_x <= vx;
        dir_y <= vy;
        dir_z <= vz;
        do
            @(posedge clk);
        while (in_stall);
        rays_sent++;
    endtask

    function automatic rci_pkg::val_t near(input int span);
        return rci_pkg::val_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // mostly rays aimed near the cylinder, some full range noise
    task automatic random_ray();
        int pick;
        pick = $urandom_range(99);
        if (pick < 78)
            send_ray(cur_cx + near(8 * ONE), cur_cy + near(8 * ONE), cur_cz + near(8 * ONE),
                     near(2 * ONE), near(2 * ONE), near(2 * ONE));
        else if (pick < 88)
            send_ray(near(200 * ONE), near(200 * ONE), near(200 * ONE),
                     near(ONE / 8), near(ONE / 8), near(ONE / 8));
        else
            send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid <= 1'b0;
        origin_x <= '0; origin_y <= '0; origin_z <= '0;
        dir_x <= '0; dir_y <= '0; dir_z <= '0;
        cfg_we <= 1'b0;
        cfg_index <= rci_pkg::CFG_CENTER_X;
        cfg_data <= '0;
        calm = 1'b0;
        hold_now = 1'b0;
        rays_sent = 0;
        idle_cycles = 0;
        cur_cx = '0; cur_cy = '0; cur_cz = '0;
        repeat (2) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed rays against the reset cylinder (unit radius about y)
        send_ray(-5 * ONE, 0, 0, ONE, 0, 0);
        send_ray(5 * ONE, 0, 0, ONE, 0, 0);
        send_ray(0, 0, 0, ONE, 0, 0);
        send_ray(-5 * ONE, 0, ONE, ONE, 0, 0);
        send_ray(-5 * ONE, 0, 3 * ONE, ONE, 0, 0);
        send_ray(-5 * ONE, ONE, 0, 0, ONE, 0);
        send_ray(ONE, 2 * ONE, 3 * ONE, 0, 0, 0);
        send_ray(-200 * ONE, 0, 0, ONE, 0, 0);
        send_ray(-149 * ONE, 0, 0, ONE, 0, 0);
        send_ray(0, 0, -5 * ONE, -ONE, 0, ONE);
        send_ray(3 * ONE, 7 * ONE, -2 * ONE, -1, -1, -1);
        send_ray(rci_pkg::VAL_MAX, rci_pkg::VAL_MAX, rci_pkg::VAL_MAX,
                 rci_pkg::VAL_MAX, rci_pkg::VAL_MAX, rci_pkg::VAL_MAX);
        send_ray(rci_pkg::VAL_MIN, rci_pkg::VAL_MIN, rci_pkg::VAL_MIN,
                 rci_pkg::VAL_MIN, rci_pkg::VAL_MIN, rci_pkg::VAL_MIN);
        send_ray(rci_pkg::VAL_MIN, 0, rci_pkg::VAL_MAX, rci_pkg::VAL_MAX, 0, rci_pkg::VAL_MIN);
        send_ray(-ONE, 0, 0, 1, 0, 0);
        send_ray(-5 * ONE, 0, 0, rci_pkg::VAL_MAX, 0, 0);
        send_ray(-3 * ONE, 0, 0, ONE / 2, 0, ONE / 2);
        send_ray('1, '1, '1, '1, '1, '1);
        repeat (300) random_ray();
        drain();

        // axis along z, shifted centre, wider radius; long result hold-off
        set_cylinder(3 * ONE / 2, -2 * ONE, ONE / 4, 0, 0, ONE, 2 * ONE, 100 * ONE);
        repeat (50) random_ray();
        hold_now = 1'b1;
        repeat (350) random_ray();
        drain();

        // register extremes
        set_cylinder(rci_pkg::VAL_MAX, rci_pkg::VAL_MIN, 0, rci_pkg::VAL_MIN,
                     rci_pkg::VAL_MAX, -1, 32'hffffffff, 32'h7fffffff);
        send_ray(0, 0, 0, ONE, ONE, ONE);
        send_ray(rci_pkg::VAL_MIN, rci_pkg::VAL_MAX, 0, -ONE, ONE, 0);
        repeat (300) random_ray();
        drain();

        // zero radius and zero distance, axis along x, no idling for a while
        set_cylinder(0, 0, 0, ONE, 0, 0, 32'h80000000, 0);
        calm = 1'b1;
        send_ray(0, 0, 0, 0, ONE, 0);
        send_ray(0, -ONE, 0, 0, ONE, 0);
        repeat (300) random_ray();
        calm = 1'b0;
        drain();

        // tilted axis with random shape, several settings
        repeat (4)
        begin
            set_cylinder(near(4 * ONE), near(4 * ONE), near(4 * ONE),
                         near(2 * ONE), near(2 * ONE), near(2 * ONE),
                         $urandom_range(0, 4 * ONE), $urandom_range(0, 50 * ONE));
            repeat (170) random_ray();
            drain();
        end

        $display("%0d rays over 8 cylinder settings, %0d results, %0d hits",
                 rays_sent, result_count, hit_count);
        if (fail_count == 0 && pending == 0)
            $display("ray_cylinder_intersect verification clean");
        else
            $display("ray_cylinder_intersect verification failed");
        $finish;
    end

endmodule
